/* design/qc_pkg.sv */
// Shared constants and types for the quadrant classifier.
// No dependencies.
package qc_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 8;
    localparam int TEST_BITS      = 16;
    localparam logic [TEST_BITS-1:0] TEST_MAX = '1;

    localparam logic [2:0] OP_LOAD     = 3'd0;
    localparam logic [2:0] OP_TRAIN    = 3'd1;
    localparam logic [2:0] OP_TEST     = 3'd2;
    localparam logic [2:0] OP_CLASSIFY = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        TR_IDLE,
        TR_BOX,
        TR_GRID,
        TR_EVAL,
        TR_DONE
    } tr_state_t;

endpackage

/* design/qc_if.sv */
// Handshake channels for command beats and result beats.
// Depends on qc_pkg for the counter width.
interface qc_item_if #(parameter int CW = 8);
    logic                 valid;
    logic                 ready;
    logic [2:0]           opcode;
    logic signed [CW-1:0] coord_x;
    logic signed [CW-1:0] coord_y;
    logic                 class_label;
    modport source (output valid, opcode, coord_x, coord_y, class_label, input ready);
    modport sink   (input valid, opcode, coord_x, coord_y, class_label, output ready);
endinterface

interface qc_result_if #(parameter int CW = 8, parameter int EW = 11);
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic signed [CW-1:0]             sep_x;
    logic signed [CW-1:0]             sep_y;
    logic [3:0]                       region_labels;
    logic [EW-1:0]                    min_errors;
    logic                             predicted;
    logic                             mismatch;
    logic [qc_pkg::TEST_BITS-1:0]     tests_seen;
    logic [qc_pkg::TEST_BITS-1:0]     tests_wrong;
    modport source (output valid, status, sep_x, sep_y, region_labels, min_errors,
                    predicted, mismatch, tests_seen, tests_wrong, input ready);
    modport sink   (input valid, status, sep_x, sep_y, region_labels, min_errors,
                    predicted, mismatch, tests_seen, tests_wrong, output ready);
endinterface

/* design/qc_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module qc_ram #(
    parameter int W = 17,
    parameter int D = 1024
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  waddr,
    input  logic [W-1:0]                        wdata,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  raddr,
    output logic [W-1:0]                        rdata
);
    logic [W-1:0] mem [0:D-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/qc_trainer.sv */
// Training sequencer: bounding box sweep, then per separator a point sweep
// that fills quadrant counts, then 16 labelling evaluations. Uses qc_pkg.
module qc_trainer #(
    parameter int MAX_POINTS = qc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = qc_pkg::COORD_BITS_DEF,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int EW = $clog2(MAX_POINTS + 1),
    localparam int PW = 2 * COORD_BITS + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [EW-1:0]         count,
    output logic [AW-1:0]         raddr,
    input  logic [PW-1:0]         rdata,
    output logic                  done,
    output logic [COORD_BITS-1:0] best_x,
    output logic [COORD_BITS-1:0] best_y,
    output logic [3:0]            best_labels,
    output logic [EW-1:0]         best_errors
);
    localparam int C = COORD_BITS;

    qc_pkg::tr_state_t state_reg, state_next;
    logic [EW-1:0] idx_reg;
    logic          pend_reg;
    logic [C-1:0]  xlo_reg, xhi_reg, ylo_reg, yhi_reg, gx_reg, gy_reg;
    logic [EW-1:0] q_reg [0:1][0:3];
    logic [3:0]    lab_reg;
    logic [EW-1:0] best_reg;
    logic          have_reg;
    logic [3:0]    bi_reg;
    logic [C-1:0]  bx_reg, by_reg;

    logic          sweeping, issue, sweep_end;
    logic [C-1:0]  px, py;
    logic          pc;
    logic [1:0]    region;
    logic [3:0]    lab_val;
    logic [EW-1:0] err;
    logic          take;

    assign sweeping  = (state_reg == qc_pkg::TR_BOX) || (state_reg == qc_pkg::TR_GRID);
    assign issue     = sweeping && (idx_reg != count);
    assign sweep_end = sweeping && (idx_reg == count) && !pend_reg;
    assign raddr     = idx_reg[AW-1:0];

    // offset binary keeps signed order under unsigned compare
    assign px     = {~rdata[C-1], rdata[C-2:0]};
    assign py     = {~rdata[2*C-1], rdata[2*C-2:C]};
    assign pc     = rdata[2*C];
    assign region = {py <= gy_reg, px > gx_reg};

    assign lab_val = ~lab_reg;
    assign err = q_reg[~lab_val[3]][0] + q_reg[~lab_val[2]][1]
               + q_reg[~lab_val[1]][2] + q_reg[~lab_val[0]][3];
    assign take = !have_reg || (err < best_reg) || ((err == best_reg) && (lab_reg >= bi_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qc_pkg::TR_IDLE: if (start) state_next = qc_pkg::TR_BOX;
            qc_pkg::TR_BOX:  if (sweep_end) state_next = qc_pkg::TR_GRID;
            qc_pkg::TR_GRID: if (sweep_end) state_next = qc_pkg::TR_EVAL;
            qc_pkg::TR_EVAL:
            begin
                if (lab_reg == 4'hF)
                begin
                    if ((gy_reg == yhi_reg) && (gx_reg == xhi_reg))
                        state_next = qc_pkg::TR_DONE;
                    else
                        state_next = qc_pkg::TR_GRID;
                end
            end
            qc_pkg::TR_DONE: state_next = qc_pkg::TR_IDLE;
            default:         state_next = qc_pkg::TR_IDLE;
        endcase
    end

    always_comb
    begin
        done        = (state_reg == qc_pkg::TR_DONE);
        best_x      = {~bx_reg[C-1], bx_reg[C-2:0]};
        best_y      = {~by_reg[C-1], by_reg[C-2:0]};
        best_labels = ~bi_reg;
        best_errors = best_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qc_pkg::TR_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            idx_reg <= idx_reg + 1'b1;
        case (state_reg)
            qc_pkg::TR_IDLE:
            begin
                idx_reg  <= '0;
                xlo_reg  <= '1;
                ylo_reg  <= '1;
                xhi_reg  <= '0;
                yhi_reg  <= '0;
                have_reg <= 1'b0;
                for (int c = 0; c < 2; c++)
                    for (int r = 0; r < 4; r++)
                        q_reg[c][r] <= '0;
            end
            qc_pkg::TR_BOX:
            begin
                if (pend_reg)
                begin
                    if (px < xlo_reg) xlo_reg <= px;
                    if (px > xhi_reg) xhi_reg <= px;
                    if (py < ylo_reg) ylo_reg <= py;
                    if (py > yhi_reg) yhi_reg <= py;
                end
                if (sweep_end)
                begin
                    idx_reg <= '0;
                    gx_reg  <= xlo_reg;
                    gy_reg  <= ylo_reg;
                end
            end
            qc_pkg::TR_GRID:
            begin
                if (pend_reg)
                    q_reg[pc][region] <= q_reg[pc][region] + 1'b1;
                if (sweep_end)
                    lab_reg <= '0;
            end
            qc_pkg::TR_EVAL:
            begin
                lab_reg <= lab_reg + 1'b1;
                if (take)
                begin
                    have_reg <= 1'b1;
                    best_reg <= err;
                    bi_reg   <= lab_reg;
                    bx_reg   <= gx_reg;
                    by_reg   <= gy_reg;
                end
                if (lab_reg == 4'hF)
                begin
                    idx_reg <= '0;
                    for (int c = 0; c < 2; c++)
                        for (int r = 0; r < 4; r++)
                            q_reg[c][r] <= '0;
                    if (gy_reg == yhi_reg)
                    begin
                        gy_reg <= ylo_reg;
                        gx_reg <= gx_reg + 1'b1;
                    end
                    else
                        gy_reg <= gy_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

/* design/quadrant_classifier_train_test.sv */
// Quadrant classifier (top level): command decode, model and test counters,
// result register. Uses qc_pkg, qc_if, qc_ram, qc_trainer.
//
// Usage: command beats arrive on the item channel (load, train, test,
// classify, clear); every command returns exactly one beat on the result
// channel, in order. For load, test, classify, clear and unknown opcodes
// the result is registered at the accepting edge and visible on the next
// cycle. Train reads the point memory once per point per sweep: a sweep
// for the bounding box, then for each separator in the box a sweep that
// fills the quadrant counts, followed by the labelling evaluations, and a
// final step to load the model. Train on an empty store is answered at
// the accepting edge with the empty status. One command is in flight at a
// time; a new beat is taken while the previous result is being taken. If
// the receiver stalls, the result holds and no new command is taken.
// Reset empties the store, clears the model and counters; the memory
// needs no clearing pass.
module quadrant_classifier_train_test #(
    parameter int MAX_POINTS = qc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = qc_pkg::COORD_BITS_DEF,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int EW = $clog2(MAX_POINTS + 1),
    localparam int PW = 2 * COORD_BITS + 1
) (
    input logic clk,
    input logic rst_n,
    qc_item_if.sink     item,
    qc_result_if.source result
);
    localparam int C  = COORD_BITS;
    localparam int TB = qc_pkg::TEST_BITS;
    localparam logic [EW-1:0] MAX_CNT = EW'(MAX_POINTS);

    logic [EW-1:0]  count_reg;
    logic [C-1:0]   mx_reg, my_reg;
    logic [3:0]     mlab_reg;
    logic [EW-1:0]  merr_reg;
    logic [TB-1:0]  tt_reg, tf_reg;
    logic           busy_reg;
    logic           ov_reg;
    logic [1:0]     st_reg;
    logic           pred_reg, mis_reg;

    logic           accept, full, tr_start, tr_done, we;
    logic           top, left, pred, mis;
    logic [1:0]     bit_sel;
    logic [AW-1:0]  raddr;
    logic [PW-1:0]  rdata;
    logic [C-1:0]   bx, by;
    logic [3:0]     blab;
    logic [EW-1:0]  berr;

    assign item.ready = !busy_reg && (!ov_reg || result.ready);
    assign accept     = item.valid && item.ready;
    assign full       = (count_reg == MAX_CNT);
    assign we         = accept && (item.opcode == qc_pkg::OP_LOAD) && !full;
    assign tr_start   = accept && (item.opcode == qc_pkg::OP_TRAIN) && (count_reg != '0);

    assign top     = item.coord_y > $signed(my_reg);
    assign left    = item.coord_x <= $signed(mx_reg);
    assign bit_sel = {top, left};
    assign pred    = mlab_reg[bit_sel];
    assign mis     = pred != item.class_label;

    qc_ram #(.W(PW), .D(MAX_POINTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({item.class_label, item.coord_y, item.coord_x}),
        .raddr (raddr),
        .rdata (rdata)
    );

    qc_trainer #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_trainer (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (tr_start),
        .count       (count_reg),
        .raddr       (raddr),
        .rdata       (rdata),
        .done        (tr_done),
        .best_x      (bx),
        .best_y      (by),
        .best_labels (blab),
        .best_errors (berr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mx_reg    <= '0;
            my_reg    <= '0;
            mlab_reg  <= '0;
            merr_reg  <= '0;
            tt_reg    <= '0;
            tf_reg    <= '0;
            busy_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            st_reg    <= qc_pkg::ST_OK;
            pred_reg  <= 1'b0;
            mis_reg   <= 1'b0;
        end
        else
        begin
            if (result.ready)
                ov_reg <= 1'b0;
            if (tr_done)
            begin
                busy_reg <= 1'b0;
                mx_reg   <= bx;
                my_reg   <= by;
                mlab_reg <= blab;
                merr_reg <= berr;
                ov_reg   <= 1'b1;
                st_reg   <= qc_pkg::ST_OK;
                pred_reg <= 1'b0;
                mis_reg  <= 1'b0;
            end
            if (accept)
            begin
                ov_reg   <= !tr_start;
                busy_reg <= tr_start;
                st_reg   <= qc_pkg::ST_OK;
                pred_reg <= 1'b0;
                mis_reg  <= 1'b0;
                case (item.opcode)
                    qc_pkg::OP_LOAD:
                    begin
                        if (full)
                            st_reg <= qc_pkg::ST_FULL;
                        else
                            count_reg <= count_reg + 1'b1;
                    end
                    qc_pkg::OP_TRAIN:
                    begin
                        if (count_reg == '0)
                            st_reg <= qc_pkg::ST_EMPTY;
                    end
                    qc_pkg::OP_TEST:
                    begin
                        pred_reg <= pred;
                        mis_reg  <= mis;
                        if (tt_reg != qc_pkg::TEST_MAX)
                            tt_reg <= tt_reg + 1'b1;
                        if (mis && (tf_reg != qc_pkg::TEST_MAX))
                            tf_reg <= tf_reg + 1'b1;
                    end
                    qc_pkg::OP_CLASSIFY:
                    begin
                        pred_reg <= pred;
                    end
                    qc_pkg::OP_CLEAR:
                    begin
                        count_reg <= '0;
                        mx_reg    <= '0;
                        my_reg    <= '0;
                        mlab_reg  <= '0;
                        merr_reg  <= '0;
                        tt_reg    <= '0;
                        tf_reg    <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign result.valid         = ov_reg;
    assign result.status        = st_reg;
    assign result.sep_x         = mx_reg;
    assign result.sep_y         = my_reg;
    assign result.region_labels = mlab_reg;
    assign result.min_errors    = merr_reg;
    assign result.predicted     = pred_reg;
    assign result.mismatch      = mis_reg;
    assign result.tests_seen    = tt_reg;
    assign result.tests_wrong   = tf_reg;
endmodule
